### rtl/stereo_chunk_linear_resampler_macros.svh
// Assertion helpers shared by the checker files.
// Both forms sample on clk and are off while arst_n is low.
`ifndef STEREO_CHUNK_LINEAR_RESAMPLER_MACROS_SVH
`define STEREO_CHUNK_LINEAR_RESAMPLER_MACROS_SVH

// Consequent holds in the same cycle as the antecedent
`define SCLR_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sclr: same-cycle check failed");

// Consequent holds in the cycle after the antecedent
`define SCLR_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sclr: next-cycle check failed");

`endif

### rtl/sclr_pkg.sv
package sclr_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int FRAMES_W   = 11;
	localparam int OUT_IDX_W  = 10;
	localparam int REM_W      = 9;
	localparam int NUM_W      = 26;
	localparam int MAG_W      = 24;
	localparam int RECIP_W    = 25;
	localparam int RECIP_SH   = 33;
	localparam int PROD_W     = MAG_W + RECIP_W;

	localparam int OUT_FRAMES    = 512;
	localparam int MAX_IN_FRAMES = 1024;
	localparam int FRAMES_MIN    = 16;
	localparam int FRAMES_RESET  = 512;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	// Denominator of the position fraction, one less than the chunk output length
	localparam logic [REM_W:0] DEN = (REM_W + 1)'(OUT_FRAMES - 1);
	localparam logic [OUT_IDX_W-1:0] OUT_LAST = OUT_IDX_W'(OUT_FRAMES - 1);
	// ceil(2^33 / 511): exact floor division by 511 for magnitudes below 2^24
	localparam logic [RECIP_W-1:0] RECIP = 25'd16810049;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_sample;
		logic signed [SAMPLE_W-1:0] right_sample;
	} frame_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] out_left;
		logic signed [SAMPLE_W-1:0] out_right;
		logic                       run_last;
		logic                       chunk_last;
	} res_t;

	// One interpolation job: out = trunc((511*a + rem*(b-a)) / 511) per channel
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] a_left;
		logic signed [SAMPLE_W-1:0] b_left;
		logic signed [SAMPLE_W-1:0] a_right;
		logic signed [SAMPLE_W-1:0] b_right;
		logic [REM_W-1:0]           rem;
		logic                       run_last;
		logic                       chunk_last;
	} job_t;

	// Queue status seen by the producer and the consumer
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

### rtl/stereo_chunk_linear_resampler.sv
// Stereo linear resampler: each chunk of frames_in stereo frames (saturated to 16..1024,
// reset 512) becomes 512 output frames, output j at position j*(frames_in-1)/511,
// each sample trunc((511*a + r*(b-a))/511). Outputs leave as soon as both bracketing
// frames are in; run_last marks the last output a frame causes, chunk_last marks output
// 511, which is the chunk's final frame itself. A frame holds the front end (frame_stall)
// from its acceptance until the last output it causes has been queued, so a new frame is
// not taken before the last is through; the sequencer issues one job a cycle into a
// four-entry queue while it is not full. The back end is a three-stage arithmetic pipe (numerator,
// reciprocal multiply, sign) ending in the output register; a stalled output freezes
// the pipe and, once the queue fills, the front end. Writing frames_in restarts the
// chunk and keeps the previous frame; write it only while idle.
module stereo_chunk_linear_resampler (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          frame_valid,
	output logic                          frame_stall,
	input  sclr_pkg::frame_t              frame,
	output logic                          res_valid,
	input  logic                          res_stall,
	output sclr_pkg::res_t                res,
	input  logic                          cfg_we,
	input  logic [sclr_pkg::FRAMES_W-1:0] cfg_wdata
);
	import sclr_pkg::*;

	logic      push;
	job_t      push_job;
	logic      pop;
	job_t      pop_job;
	q_status_t q_status;

	sclr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.frame       (frame),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.push        (push),
		.job         (push_job),
		.q_status    (q_status)
	);

	sclr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.q_status (q_status)
	);

	sclr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.job       (pop_job),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

### rtl/sclr_front.sv
module sclr_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            frame_valid,
	output logic                            frame_stall,
	input  sclr_pkg::frame_t                frame,
	input  logic                            cfg_we,
	input  logic [sclr_pkg::FRAMES_W-1:0]   cfg_wdata,
	output logic                            push,
	output sclr_pkg::job_t                  job,
	input  sclr_pkg::q_status_t             q_status
);
	import sclr_pkg::*;

	logic                       busy_q;
	frame_t                     cur_q;
	logic signed [SAMPLE_W-1:0] prev_l_q;
	logic signed [SAMPLE_W-1:0] prev_r_q;
	logic [FRAMES_W-1:0]        in_count_q;
	logic [OUT_IDX_W-1:0]       out_count_q;
	logic [FRAMES_W-1:0]        pos_whole_q;
	logic [REM_W-1:0]           pos_rem_q;
	logic [FRAMES_W-1:0]        n_q;
	logic [1:0]                 step_whole_q;
	logic [REM_W-1:0]           step_rem_q;

	logic [FRAMES_W-1:0]  cfg_n;
	logic [FRAMES_W-1:0]  cfg_nm1;
	logic [1:0]           cfg_step_whole;
	logic [REM_W-1:0]     cfg_step_rem;

	logic [FRAMES_W-1:0]  need;
	logic                 due;
	logic                 chunk_end;
	logic [REM_W:0]       sum_rem;
	logic                 wrap;
	logic [REM_W-1:0]     nxt_rem;
	logic [FRAMES_W-1:0]  nxt_whole;
	logic [FRAMES_W-1:0]  nxt_need;
	logic                 last_out;
	logic                 finish;
	logic                 last_frame;
	logic                 restart;

	// Saturate the chunk length and split (n-1) into whole and remainder over 511
	always_comb begin
		if (cfg_wdata < FRAMES_W'(FRAMES_MIN)) begin
			cfg_n = FRAMES_W'(FRAMES_MIN);
		end else if (cfg_wdata > FRAMES_W'(MAX_IN_FRAMES)) begin
			cfg_n = FRAMES_W'(MAX_IN_FRAMES);
		end else begin
			cfg_n = cfg_wdata;
		end
		cfg_nm1 = cfg_n - FRAMES_W'(1);
		if (cfg_nm1 >= FRAMES_W'(2) * FRAMES_W'(DEN)) begin
			cfg_step_whole = 2'd2;
			cfg_step_rem   = REM_W'(cfg_nm1 - FRAMES_W'(2) * FRAMES_W'(DEN));
		end else if (cfg_nm1 >= FRAMES_W'(DEN)) begin
			cfg_step_whole = 2'd1;
			cfg_step_rem   = REM_W'(cfg_nm1 - FRAMES_W'(DEN));
		end else begin
			cfg_step_whole = 2'd0;
			cfg_step_rem   = REM_W'(cfg_nm1);
		end
	end

	// Decide whether the held frame completes the next output, and look one output ahead
	always_comb begin
		need       = pos_whole_q + FRAMES_W'(pos_rem_q != '0);
		due        = busy_q && (need == in_count_q);
		chunk_end  = (out_count_q == OUT_LAST);
		sum_rem    = {1'b0, pos_rem_q} + {1'b0, step_rem_q};
		wrap       = (sum_rem >= DEN);
		nxt_rem    = wrap ? REM_W'(sum_rem - DEN) : sum_rem[REM_W-1:0];
		nxt_whole  = pos_whole_q + FRAMES_W'(step_whole_q) + FRAMES_W'(wrap);
		nxt_need   = nxt_whole + FRAMES_W'(nxt_rem != '0);
		last_out   = chunk_end || (nxt_need != in_count_q);
		push       = due && !q_status.full;
		finish     = busy_q && (!due || (push && last_out));
		last_frame = ((in_count_q + FRAMES_W'(1)) >= n_q);
		restart    = (push && chunk_end) || last_frame;
	end

	// Build the job; an output sitting on a frame takes that frame as is
	always_comb begin
		job.b_left     = cur_q.left_sample;
		job.b_right    = cur_q.right_sample;
		job.run_last   = last_out;
		job.chunk_last = chunk_end;
		if (pos_rem_q == '0) begin
			job.a_left  = cur_q.left_sample;
			job.a_right = cur_q.right_sample;
			job.rem     = '0;
		end else begin
			job.a_left  = prev_l_q;
			job.a_right = prev_r_q;
			job.rem     = pos_rem_q;
		end
	end

	assign frame_stall = busy_q;

	// Hold the accepted frame
	always_ff @(posedge clk) begin
		if (frame_valid && !frame_stall) begin
			cur_q <= frame;
		end
	end

	// Advance position and chunk counters; a configuration write restarts the chunk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			prev_l_q     <= '0;
			prev_r_q     <= '0;
			in_count_q   <= '0;
			out_count_q  <= '0;
			pos_whole_q  <= '0;
			pos_rem_q    <= '0;
			n_q          <= FRAMES_W'(FRAMES_RESET);
			step_whole_q <= 2'd1;
			step_rem_q   <= '0;
		end else begin
			if (frame_valid && !frame_stall) begin
				busy_q <= 1'b1;
			end
			if (push && !chunk_end) begin
				out_count_q <= out_count_q + OUT_IDX_W'(1);
				pos_whole_q <= nxt_whole;
				pos_rem_q   <= nxt_rem;
			end
			if (finish) begin
				busy_q   <= 1'b0;
				prev_l_q <= cur_q.left_sample;
				prev_r_q <= cur_q.right_sample;
				if (restart) begin
					in_count_q  <= '0;
					out_count_q <= '0;
					pos_whole_q <= '0;
					pos_rem_q   <= '0;
				end else begin
					in_count_q <= in_count_q + FRAMES_W'(1);
				end
			end
			if (cfg_we) begin
				n_q          <= cfg_n;
				step_whole_q <= cfg_step_whole;
				step_rem_q   <= cfg_step_rem;
				in_count_q   <= '0;
				out_count_q  <= '0;
				pos_whole_q  <= '0;
				pos_rem_q    <= '0;
			end
		end
	end

endmodule

### rtl/sclr_queue.sv
module sclr_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  sclr_pkg::job_t       push_job,
	input  logic                 pop,
	output sclr_pkg::job_t       pop_job,
	output sclr_pkg::q_status_t  q_status
);
	import sclr_pkg::*;

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	always_comb begin
		q_status.full  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
		q_status.empty = (count_q == '0);
		do_push        = push && !q_status.full;
		do_pop         = pop && !q_status.empty;
		pop_job        = mem_q[rd_ptr_q];
	end

	// Write the entry at the tail
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (QPTR_W + 1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (QPTR_W + 1)'(1);
			end
		end
	end

endmodule

### rtl/sclr_back.sv
module sclr_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sclr_pkg::q_status_t  q_status,
	input  sclr_pkg::job_t       job,
	output logic                 pop,
	output logic                 res_valid,
	input  logic                 res_stall,
	output sclr_pkg::res_t       res
);
	import sclr_pkg::*;

	// 511*a + rem*(b-a); magnitude stays at most 511*32768
	function automatic logic signed [NUM_W-1:0] numer(
		input logic signed [SAMPLE_W-1:0] a,
		input logic signed [SAMPLE_W-1:0] b,
		input logic [REM_W-1:0]           r
	);
		logic signed [SAMPLE_W:0]  diff;
		logic signed [NUM_W:0]     prod;
		logic signed [NUM_W:0]     a_ext;
		logic signed [NUM_W:0]     a511;
		logic signed [NUM_W:0]     sum;
		diff  = $signed({b[SAMPLE_W-1], b}) - $signed({a[SAMPLE_W-1], a});
		a_ext = $signed({{(NUM_W + 1 - SAMPLE_W){a[SAMPLE_W-1]}}, a});
		prod  = $signed({{(NUM_W - REM_W + 1){1'b0}}, r})
			* $signed({{(NUM_W - SAMPLE_W){diff[SAMPLE_W]}}, diff});
		a511  = (a_ext <<< REM_W) - a_ext;
		sum   = a511 + prod;
		return sum[NUM_W-1:0];
	endfunction

	// Magnitude over 511, floor, by reciprocal multiply
	function automatic logic [SAMPLE_W-1:0] quot(input logic signed [NUM_W-1:0] num);
		logic [NUM_W-1:0]  mag;
		logic [PROD_W-1:0] p;
		mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
		p   = PROD_W'(mag[MAG_W-1:0]) * PROD_W'(RECIP);
		return p[RECIP_SH +: SAMPLE_W];
	endfunction

	logic                    en;
	logic                    v_s1;
	logic signed [NUM_W-1:0] num_l_s1;
	logic signed [NUM_W-1:0] num_r_s1;
	logic                    run_last_s1;
	logic                    chunk_last_s1;
	logic                    v_s2;
	logic [SAMPLE_W-1:0]     q_l_s2;
	logic [SAMPLE_W-1:0]     q_r_s2;
	logic                    neg_l_s2;
	logic                    neg_r_s2;
	logic                    run_last_s2;
	logic                    chunk_last_s2;
	logic                    res_valid_q;
	res_t                    res_q;

	// Advance the whole pipe unless a finished result is stuck at the output
	assign en        = !(res_valid_q && res_stall);
	assign pop       = en && !q_status.empty;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= pop;
			v_s2        <= v_s1;
			res_valid_q <= v_s2;
		end
	end

	// Numerator, reciprocal multiply, sign restore
	always_ff @(posedge clk) begin
		if (en) begin
			num_l_s1      <= numer(job.a_left, job.b_left, job.rem);
			num_r_s1      <= numer(job.a_right, job.b_right, job.rem);
			run_last_s1   <= job.run_last;
			chunk_last_s1 <= job.chunk_last;

			q_l_s2        <= quot(num_l_s1);
			q_r_s2        <= quot(num_r_s1);
			neg_l_s2      <= num_l_s1[NUM_W-1];
			neg_r_s2      <= num_r_s1[NUM_W-1];
			run_last_s2   <= run_last_s1;
			chunk_last_s2 <= chunk_last_s1;

			res_q.out_left   <= neg_l_s2 ? $signed(-q_l_s2) : $signed(q_l_s2);
			res_q.out_right  <= neg_r_s2 ? $signed(-q_r_s2) : $signed(q_r_s2);
			res_q.run_last   <= run_last_s2;
			res_q.chunk_last <= chunk_last_s2;
		end
	end

endmodule

### rtl/sclr_checker.sv
`include "stereo_chunk_linear_resampler_macros.svh"

module sclr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          frame_valid,
	input logic                          frame_stall,
	input sclr_pkg::frame_t              frame,
	input logic                          res_valid,
	input logic                          res_stall,
	input sclr_pkg::res_t                res,
	input logic                          cfg_we,
	input logic [sclr_pkg::FRAMES_W-1:0] cfg_wdata
);
	import sclr_pkg::*;

	// Hold a stalled result
	`SCLR_NEXT(a_res_hold, res_valid && res_stall, res_valid)
	`SCLR_NEXT(a_res_stable, res_valid && res_stall, $stable(res))

	// The output ending a chunk is always the last one its frame causes
	`SCLR_SAME(a_chunk_run, res_valid && res.chunk_last, res.run_last)

	// A transferred frame makes the front end busy in the next cycle
	`SCLR_NEXT(a_frame_busy, frame_valid && !frame_stall, frame_stall)

endmodule

bind stereo_chunk_linear_resampler sclr_checker u_sclr_checker (.*);
